// ===== rtl/nec_ir_pkg.sv =====
// shared types and constants of the nec ir symbol decoder
package nec_ir_pkg;

	localparam int unsigned DATA_BITS   = 32;
	localparam int unsigned MARGIN_W    = 12;
	localparam int unsigned TICKS_W     = 15;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned BAD_W       = 6;
	localparam int unsigned CFG_INDEX_W = 3;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_MARGIN       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEADING_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LEADING_LOW  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_HIGH  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_LOW   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BIT_HIGH     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW      = 3'd7;

	// register reset values
	localparam logic [MARGIN_W-1:0] RST_MARGIN       = 12'd200;
	localparam logic [TICKS_W-1:0]  RST_LEADING_HIGH = 15'd9000;
	localparam logic [TICKS_W-1:0]  RST_LEADING_LOW  = 15'd4500;
	localparam logic [TICKS_W-1:0]  RST_REPEAT_HIGH  = 15'd9000;
	localparam logic [TICKS_W-1:0]  RST_REPEAT_LOW   = 15'd2250;
	localparam logic [TICKS_W-1:0]  RST_BIT_HIGH     = 15'd560;
	localparam logic [TICKS_W-1:0]  RST_ZERO_LOW     = 15'd560;
	localparam logic [TICKS_W-1:0]  RST_ONE_LOW      = 15'd1690;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPEAT     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_LEAD   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_DATA   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_REPEAT = 3'd4;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd5;

	// classified symbol handed from front to back
	typedef struct packed {
		logic lead;
		logic rep;
		logic one;
		logic zero;
		logic last;
	} cls_t;

	// one status item
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [DATA_BITS-1:0] word;
		logic [BAD_W-1:0]     bad;
	} res_t;

endpackage

// ===== rtl/nec_ir_fifo.sv =====
// small register queue used for the symbol queue and the status queue of the decoder
module nec_ir_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && empty))
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/nec_ir_front.sv =====
// configuration registers and window classifier of one received symbol
module nec_ir_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [nec_ir_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [nec_ir_pkg::TICKS_W-1:0]       cfg_data,
	input  logic [nec_ir_pkg::TICKS_W-1:0]       mark_ticks,
	input  logic [nec_ir_pkg::TICKS_W-1:0]       space_ticks,
	input  logic                                 last_symbol,
	output nec_ir_pkg::cls_t                     cls
);

	import nec_ir_pkg::*;

	logic [MARGIN_W-1:0] margin_q;
	logic [TICKS_W-1:0]  leading_high_q;
	logic [TICKS_W-1:0]  leading_low_q;
	logic [TICKS_W-1:0]  repeat_high_q;
	logic [TICKS_W-1:0]  repeat_low_q;
	logic [TICKS_W-1:0]  bit_high_q;
	logic [TICKS_W-1:0]  zero_low_q;
	logic [TICKS_W-1:0]  one_low_q;

	// strict window (nom - m, nom + m), checked as t < nom + m and t + m > nom
	function automatic logic in_window(
		input logic [TICKS_W-1:0]  t,
		input logic [TICKS_W-1:0]  nom,
		input logic [MARGIN_W-1:0] m
	);
		logic [TICKS_W:0] hi;
		logic [TICKS_W:0] lo;
		hi = {1'b0, nom} + (TICKS_W + 1)'(m);
		lo = {1'b0, t} + (TICKS_W + 1)'(m);
		return ({1'b0, t} < hi) && (lo > {1'b0, nom});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q       <= RST_MARGIN;
			leading_high_q <= RST_LEADING_HIGH;
			leading_low_q  <= RST_LEADING_LOW;
			repeat_high_q  <= RST_REPEAT_HIGH;
			repeat_low_q   <= RST_REPEAT_LOW;
			bit_high_q     <= RST_BIT_HIGH;
			zero_low_q     <= RST_ZERO_LOW;
			one_low_q      <= RST_ONE_LOW;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MARGIN:       margin_q       <= cfg_data[MARGIN_W-1:0];
				REG_LEADING_HIGH: leading_high_q <= cfg_data;
				REG_LEADING_LOW:  leading_low_q  <= cfg_data;
				REG_REPEAT_HIGH:  repeat_high_q  <= cfg_data;
				REG_REPEAT_LOW:   repeat_low_q   <= cfg_data;
				REG_BIT_HIGH:     bit_high_q     <= cfg_data;
				REG_ZERO_LOW:     zero_low_q     <= cfg_data;
				REG_ONE_LOW:      one_low_q      <= cfg_data;
				default:          margin_q       <= margin_q;
			endcase
		end
	end

	logic bit_mark_ok;

	assign bit_mark_ok = in_window(mark_ticks, bit_high_q, margin_q);

	assign cls.lead = in_window(mark_ticks, leading_high_q, margin_q)
		&& in_window(space_ticks, leading_low_q, margin_q);
	assign cls.rep  = in_window(mark_ticks, repeat_high_q, margin_q)
		&& in_window(space_ticks, repeat_low_q, margin_q);
	assign cls.one  = bit_mark_ok && in_window(space_ticks, one_low_q, margin_q);
	assign cls.zero = bit_mark_ok && in_window(space_ticks, zero_low_q, margin_q);
	assign cls.last = last_symbol;

endmodule

// ===== rtl/nec_ir_back.sv =====
// frame sequencer: counts symbols, collects bits and builds the status item
module nec_ir_back #(
	parameter int unsigned MAX_SYMBOLS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nec_ir_pkg::cls_t  cls,
	input  logic              cls_empty,
	output logic              cls_pop,
	input  logic              res_full,
	output logic              res_push,
	output nec_ir_pkg::res_t  res
);

	import nec_ir_pkg::*;

	localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);
	localparam logic [CW-1:0] CNT_MAX    = CW'(MAX_SYMBOLS);
	localparam logic [CW-1:0] IDX_END    = CW'(DATA_BITS + 1);
	localparam logic [CW-1:0] IDX_REPEAT = CW'(1);
	localparam logic [CW-1:0] IDX_DATA   = CW'(DATA_BITS);

	logic [CW-1:0]        count_q;
	logic [DATA_BITS-1:0] store_q;
	logic                 lead_q;
	logic                 rep_q;
	logic                 fault_q;
	logic [BAD_W-1:0]     fault_idx_q;

	logic is_data;

	// a last symbol also needs room in the result queue
	assign cls_pop  = !cls_empty && (!cls.last || !res_full);
	assign res_push = cls_pop && cls.last;
	assign is_data  = (count_q != '0) && (count_q <= IDX_DATA);

	always_comb begin
		res.word = '0;
		res.bad  = '0;
		if (count_q == IDX_END) begin
			if (!lead_q) begin
				res.status = ST_BAD_LEAD;
			end else if (fault_q) begin
				res.status = ST_BAD_DATA;
				res.bad    = fault_idx_q;
			end else begin
				res.status = ST_OK;
				res.word   = store_q;
			end
		end else if (count_q == IDX_REPEAT) begin
			res.status = rep_q ? ST_REPEAT : ST_BAD_REPEAT;
		end else begin
			res.status = ST_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			store_q     <= '0;
			lead_q      <= 1'b0;
			rep_q       <= 1'b0;
			fault_q     <= 1'b0;
			fault_idx_q <= '0;
		end else if (cls_pop) begin
			if (cls.last) begin
				count_q     <= '0;
				store_q     <= '0;
				lead_q      <= 1'b0;
				rep_q       <= 1'b0;
				fault_q     <= 1'b0;
				fault_idx_q <= '0;
			end else begin
				if (count_q < CNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
				if (count_q == '0) begin
					lead_q <= cls.lead;
					rep_q  <= cls.rep;
				end else if (is_data && !fault_q) begin
					// bits arrive lsb first, so shift in from the top
					store_q <= {cls.one, store_q[DATA_BITS-1:1]};
					if (!cls.one && !cls.zero) begin
						fault_q     <= 1'b1;
						fault_idx_q <= count_q[BAD_W-1:0];
					end
				end
			end
		end
	end

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("symbol count beyond saturation");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (count_q == '0) && !fault_q && !lead_q && !rep_q)
		else $error("frame state not cleared after status item");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full && cls_pop)
		else $error("status item pushed without room");

endmodule

// ===== rtl/nec_ir_symbol_decoder_core.sv =====
// top level of the nec ir symbol decoder
//
// usage:
// - symbol input is a queue write port: an item (mark_ticks, space_ticks,
//   last_symbol) is taken at a clock edge with push high and full low
// - status output is a queue read port: the oldest status item sits on
//   status / frame_word / bad_symbol while empty is low and leaves at an
//   edge with pop high
// - configuration: cfg_valid with cfg_index and cfg_data writes one register;
//   cfg_ready is always high; write only while no frame is in flight
// - the front classifies each symbol against all windows in the accept cycle
//   and puts it in a two-entry queue; the back pulls one classified item per
//   cycle unless held, and updates the frame counter and bit shift register
// - throughput: one symbol per cycle while full is low; a status item is
//   written to the status queue when the back pops the last symbol of its frame
// - only the last symbol of a frame produces a status item; when the status
//   queue is full and a last symbol waits, the back holds, the symbol queue
//   fills and full rises
// - reset clears both queues and the frame state and loads the register
//   defaults
module nec_ir_symbol_decoder_core #(
	parameter int unsigned MAX_SYMBOLS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nec_ir_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [nec_ir_pkg::TICKS_W-1:0]      cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [nec_ir_pkg::TICKS_W-1:0]      mark_ticks,
	input  logic [nec_ir_pkg::TICKS_W-1:0]      space_ticks,
	input  logic                                last_symbol,
	output logic                                empty,
	input  logic                                pop,
	output logic [nec_ir_pkg::STATUS_W-1:0]     status,
	output logic [nec_ir_pkg::DATA_BITS-1:0]    frame_word,
	output logic [nec_ir_pkg::BAD_W-1:0]        bad_symbol
);

	import nec_ir_pkg::*;

	localparam int unsigned CLS_W = $bits(cls_t);
	localparam int unsigned RES_W = $bits(res_t);

	cls_t             cls_in;
	logic [CLS_W-1:0] cls_raw;
	cls_t             cls_out;
	logic             cls_empty;
	logic             cls_pop;
	logic             res_push;
	res_t             res_in;
	logic [RES_W-1:0] res_raw;
	res_t             res_out;
	logic             res_full;

	assign cfg_ready = 1'b1;

	nec_ir_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mark_ticks  (mark_ticks),
		.space_ticks (space_ticks),
		.last_symbol (last_symbol),
		.cls         (cls_in)
	);

	nec_ir_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (2)
	) u_cls_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !full),
		.wr_data (CLS_W'(cls_in)),
		.rd_en   (cls_pop),
		.rd_data (cls_raw),
		.full    (full),
		.empty   (cls_empty)
	);

	assign cls_out = cls_t'(cls_raw);

	nec_ir_back #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	nec_ir_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (RES_W'(res_in)),
		.rd_en   (pop && !empty),
		.rd_data (res_raw),
		.full    (res_full),
		.empty   (empty)
	);

	assign res_out    = res_t'(res_raw);
	assign status     = res_out.status;
	assign frame_word = res_out.word;
	assign bad_symbol = res_out.bad;

endmodule

// ===== dv/nec_ir_symbol_decoder_core_tb.sv =====
// self-checking testbench of the nec ir symbol decoder core: directed and random frames against a predictor
`timescale 1ns / 100ps

module nec_ir_symbol_decoder_core_tb;
	import nec_ir_pkg::*;

	localparam int MAX_SYMBOLS   = 64;
	localparam int FRAME_LEN     = 34;
	localparam int REPEAT_LEN    = 2;
	localparam int N_REGS        = 8;
	localparam int TICKS_MAX     = 32767;
	localparam int N_PHASES      = 7;
	localparam int PHASE_ITEMS   = 85;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RUN_LIMIT     = 200000;

	typedef enum {
		FR_NEC,
		FR_NEC_BAD_LEAD,
		FR_NEC_BAD_DATA,
		FR_REPEAT,
		FR_REPEAT_BAD,
		FR_ODD,
		FR_LONG,
		FR_NOISE
	} frame_kind_e;

	class status_scoreboard;
		int unsigned          cfg_reg [N_REGS];
		int                   sym_idx;
		logic [DATA_BITS-1:0] bit_acc;
		bit                   lead_ok;
		bit                   rep_ok;
		bit                   data_bad;
		logic [BAD_W-1:0]     bad_idx;
		res_t                 status_q [$];
		int                   errors;
		int                   checked;

		function new();
			cfg_reg[REG_MARGIN]       = RST_MARGIN;
			cfg_reg[REG_LEADING_HIGH] = RST_LEADING_HIGH;
			cfg_reg[REG_LEADING_LOW]  = RST_LEADING_LOW;
			cfg_reg[REG_REPEAT_HIGH]  = RST_REPEAT_HIGH;
			cfg_reg[REG_REPEAT_LOW]   = RST_REPEAT_LOW;
			cfg_reg[REG_BIT_HIGH]     = RST_BIT_HIGH;
			cfg_reg[REG_ZERO_LOW]     = RST_ZERO_LOW;
			cfg_reg[REG_ONE_LOW]      = RST_ONE_LOW;
			errors = 0;
			checked = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			sym_idx = 0;
			bit_acc = '0;
			lead_ok = 1'b0;
			rep_ok = 1'b0;
			data_bad = 1'b0;
			bad_idx = '0;
		endfunction

		function void write_reg(int idx, logic [TICKS_W-1:0] data);
			if (idx == REG_MARGIN) begin
				cfg_reg[idx] = data[MARGIN_W-1:0];
			end else begin
				cfg_reg[idx] = data;
			end
		endfunction

		// strict window; the lower bound may go below zero
		function bit in_window(logic [TICKS_W-1:0] ticks, int unsigned nominal);
			int t;
			int n;
			int m;
			t = int'(ticks);
			n = int'(nominal);
			m = int'(cfg_reg[REG_MARGIN]);
			return (t < n + m) && (t > n - m);
		endfunction

		function bit pair_ok(logic [TICKS_W-1:0] mark, logic [TICKS_W-1:0] space,
				int hi_idx, int lo_idx);
			return in_window(mark, cfg_reg[hi_idx]) && in_window(space, cfg_reg[lo_idx]);
		endfunction

		function void note_symbol(logic [TICKS_W-1:0] mark, logic [TICKS_W-1:0] space,
				logic last);
			int   idx;
			res_t want;
			idx = sym_idx;
			if (idx == 0) begin
				lead_ok = pair_ok(mark, space, REG_LEADING_HIGH, REG_LEADING_LOW);
				rep_ok = pair_ok(mark, space, REG_REPEAT_HIGH, REG_REPEAT_LOW);
			end else if (idx <= DATA_BITS && !data_bad) begin
				// a symbol matching both bit values counts as a one
				if (pair_ok(mark, space, REG_BIT_HIGH, REG_ONE_LOW)) begin
					bit_acc[idx-1] = 1'b1;
				end else if (pair_ok(mark, space, REG_BIT_HIGH, REG_ZERO_LOW)) begin
					bit_acc[idx-1] = 1'b0;
				end else begin
					data_bad = 1'b1;
					bad_idx = idx[BAD_W-1:0];
				end
			end
			if (!last) begin
				if (sym_idx < MAX_SYMBOLS)
					sym_idx++;
				return;
			end
			want = '0;
			if (idx + 1 == FRAME_LEN) begin
				if (!lead_ok) begin
					want.status = ST_BAD_LEAD;
				end else if (data_bad) begin
					want.status = ST_BAD_DATA;
					want.bad = bad_idx;
				end else begin
					want.status = ST_OK;
					want.word = bit_acc;
				end
			end else if (idx + 1 == REPEAT_LEN) begin
				want.status = rep_ok ? ST_REPEAT : ST_BAD_REPEAT;
			end else begin
				want.status = ST_UNKNOWN;
			end
			status_q.push_back(want);
			clear_frame();
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch at status item %0d: %s", $time, checked, msg);
		endtask

		task check_status(logic [STATUS_W-1:0] st, logic [DATA_BITS-1:0] word,
				logic [BAD_W-1:0] bad);
			res_t want;
			if (status_q.size() == 0) begin
				report_mismatch("status item with nothing expected");
				return;
			end
			want = status_q.pop_front();
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			if (word !== want.word)
				report_mismatch($sformatf("frame_word %h, expected %h", word, want.word));
			if (bad !== want.bad)
				report_mismatch($sformatf("bad_symbol %0d, expected %0d", bad, want.bad));
			checked++;
		endtask

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [TICKS_W-1:0]     cfg_data;
	logic                   push;
	logic                   full;
	logic [TICKS_W-1:0]     mark_ticks;
	logic [TICKS_W-1:0]     space_ticks;
	logic                   last_symbol;
	logic                   empty;
	logic                   pop;
	logic [STATUS_W-1:0]    status;
	logic [DATA_BITS-1:0]   frame_word;
	logic [BAD_W-1:0]       bad_symbol;

	status_scoreboard sb;
	int               items_sent;
	bit               hold_request;
	bit               burst_mode;
	bit               tx_quiet;

	nec_ir_symbol_decoder_core #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.mark_ticks(mark_ticks),
		.space_ticks(space_ticks),
		.last_symbol(last_symbol),
		.empty(empty),
		.pop(pop),
		.status(status),
		.frame_word(frame_word),
		.bad_symbol(bad_symbol)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	function automatic int clamp_ticks(int t);
		if (t < 0)
			return 0;
		if (t > TICKS_MAX)
			return TICKS_MAX;
		return t;
	endfunction

	function automatic int noise_ticks();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return TICKS_MAX;
			default: return $urandom_range(0, TICKS_MAX);
		endcase
	endfunction

	// duration around a nominal value, on the inner or outer window edges or inside; outer edges only when strict is low
	function automatic int ticks_near(int nominal, bit strict);
		int m;
		int t;
		int sel;
		m = int'(sb.cfg_reg[REG_MARGIN]);
		sel = $urandom_range(0, 9);
		if (strict && (sel == 3 || sel == 4))
			sel = 5;
		case (sel)
			0: t = nominal;
			1: t = nominal + m - 1;
			2: t = nominal - m + 1;
			3: t = nominal + m;
			4: t = nominal - m;
			default: t = (m > 0) ? nominal - (m - 1) + int'($urandom_range(0, 2 * (m - 1)))
				: nominal;
		endcase
		return clamp_ticks(t);
	endfunction

	function automatic int ticks_off(int nominal);
		int m;
		m = int'(sb.cfg_reg[REG_MARGIN]);
		case ($urandom_range(0, 2))
			0: return clamp_ticks(nominal + m);
			1: return clamp_ticks(nominal - m);
			default: return noise_ticks();
		endcase
	endfunction

	function automatic frame_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			return FR_NEC;
		if (r < 50)
			return FR_NEC_BAD_DATA;
		if (r < 58)
			return FR_NEC_BAD_LEAD;
		if (r < 73)
			return FR_REPEAT;
		if (r < 80)
			return FR_REPEAT_BAD;
		if (r < 94)
			return FR_ODD;
		return FR_NOISE;
	endfunction

	task automatic send_item(input int m, input int s, input bit last);
		int gap;
		push <= 1'b1;
		mark_ticks <= m[TICKS_W-1:0];
		space_ticks <= s[TICKS_W-1:0];
		last_symbol <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_symbol(m[TICKS_W-1:0], s[TICKS_W-1:0], last);
		items_sent++;
		gap = tx_quiet ? 0 : gap_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input frame_kind_e kind);
		int          len;
		int          bad_at;
		int          k;
		int          m;
		int          s;
		int unsigned hi;
		int unsigned lo;
		bit          bit_one;
		bit          strict;
		case (kind)
			FR_NEC, FR_NEC_BAD_LEAD, FR_NEC_BAD_DATA: len = FRAME_LEN;
			FR_REPEAT, FR_REPEAT_BAD: len = REPEAT_LEN;
			FR_LONG: len = $urandom_range(MAX_SYMBOLS - 1, MAX_SYMBOLS + 6);
			FR_NOISE: len = $urandom_range(0, 1) ? FRAME_LEN : REPEAT_LEN;
			default: begin
				len = $urandom_range(1, 40);
				if (len == FRAME_LEN || len == REPEAT_LEN)
					len = FRAME_LEN + 1;
			end
		endcase
		bad_at = $urandom_range(1, DATA_BITS);
		tx_quiet = burst_mode || ($urandom_range(0, 4) == 0);
		for (k = 0; k < len; k++) begin
			strict = ($urandom_range(0, 19) != 0);
			if (kind == FR_NOISE) begin
				m = noise_ticks();
				s = noise_ticks();
			end else if (k == 0) begin
				if (kind == FR_REPEAT || kind == FR_REPEAT_BAD) begin
					hi = sb.cfg_reg[REG_REPEAT_HIGH];
					lo = sb.cfg_reg[REG_REPEAT_LOW];
				end else begin
					hi = sb.cfg_reg[REG_LEADING_HIGH];
					lo = sb.cfg_reg[REG_LEADING_LOW];
				end
				m = ticks_near(hi, 1'b1);
				s = ticks_near(lo, 1'b1);
				if (kind == FR_REPEAT_BAD || kind == FR_NEC_BAD_LEAD) begin
					if ($urandom_range(0, 1))
						m = ticks_off(hi);
					else
						s = ticks_off(lo);
				end
			end else if (k <= DATA_BITS && len != REPEAT_LEN) begin
				bit_one = $urandom_range(0, 1);
				m = ticks_near(sb.cfg_reg[REG_BIT_HIGH], strict);
				s = ticks_near(bit_one ? sb.cfg_reg[REG_ONE_LOW] : sb.cfg_reg[REG_ZERO_LOW],
					strict);
				if (kind == FR_NEC_BAD_DATA && k == bad_at) begin
					if ($urandom_range(0, 1))
						m = ticks_off(sb.cfg_reg[REG_BIT_HIGH]);
					else
						s = noise_ticks();
				end
			end else begin
				// ending symbol and anything past the data bits
				m = ticks_near(sb.cfg_reg[REG_BIT_HIGH], 1'b0);
				s = noise_ticks();
			end
			send_item(m, s, k == len - 1);
		end
	endtask

	// short frames at default settings, window edges included
	task automatic directed_symbols();
		tx_quiet = 1'b0;
		send_item(9199, 2051, 1'b0);
		send_item(0, 0, 1'b1);
		send_item(8801, 2449, 1'b0);
		send_item(560, 560, 1'b1);
		send_item(9200, 2250, 1'b0);
		send_item(TICKS_MAX, TICKS_MAX, 1'b1);
		send_item(9000, 2050, 1'b0);
		send_item(0, TICKS_MAX, 1'b1);
		// leading code where a repeat code belongs
		send_item(9000, 4500, 1'b0);
		send_item(560, 1690, 1'b1);
		send_item(TICKS_MAX, TICKS_MAX, 1'b1);
		send_item(0, 0, 1'b0);
		send_item(TICKS_MAX, 0, 1'b0);
		send_item(0, TICKS_MAX, 1'b1);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_phase(input int phase);
		int unsigned val [N_REGS];
		int          i;
		case (phase)
			1: begin
				val[REG_MARGIN] = $urandom_range(20, 700);
				val[REG_LEADING_HIGH] = $urandom_range(2000, 30000);
				val[REG_LEADING_LOW] = $urandom_range(2000, 30000);
				val[REG_REPEAT_HIGH] = $urandom_range(2000, 30000);
				val[REG_REPEAT_LOW] = $urandom_range(2000, 30000);
				val[REG_BIT_HIGH] = $urandom_range(200, 3000);
				val[REG_ZERO_LOW] = $urandom_range(200, 3000);
				val[REG_ONE_LOW] = clamp_ticks(val[REG_ZERO_LOW] + 2 * val[REG_MARGIN]
					+ $urandom_range(0, 3000));
			end
			2: begin
				// upper data bits are dropped, margin becomes zero: nothing matches
				val[REG_MARGIN] = 15'h7000;
				for (i = 1; i < N_REGS; i++)
					val[i] = TICKS_MAX;
			end
			3: begin
				// windows reach below zero, every code and both bit values overlap
				val[REG_MARGIN] = 15'h7FFF;
				for (i = 1; i < N_REGS; i++)
					val[i] = 0;
			end
			4: begin
				val[REG_MARGIN] = 15'h0FFF;
				for (i = 1; i < N_REGS; i++)
					val[i] = TICKS_MAX;
				val[REG_ZERO_LOW] = TICKS_MAX - $urandom_range(0, 300);
			end
			5: begin
				val[REG_MARGIN] = $urandom_range(0, TICKS_MAX);
				for (i = 1; i < N_REGS; i++)
					val[i] = $urandom_range(0, TICKS_MAX);
				if ($urandom_range(0, 1))
					val[REG_ONE_LOW] = clamp_ticks(val[REG_ZERO_LOW] + $urandom_range(0, 200));
			end
			default: begin
				val[REG_MARGIN] = RST_MARGIN;
				val[REG_LEADING_HIGH] = RST_LEADING_HIGH;
				val[REG_LEADING_LOW] = RST_LEADING_LOW;
				val[REG_REPEAT_HIGH] = RST_REPEAT_HIGH;
				val[REG_REPEAT_LOW] = RST_REPEAT_LOW;
				val[REG_BIT_HIGH] = RST_BIT_HIGH;
				val[REG_ZERO_LOW] = RST_ZERO_LOW;
				val[REG_ONE_LOW] = RST_ONE_LOW;
			end
		endcase
		for (i = 0; i < N_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_INDEX_W-1:0];
			cfg_data <= val[i][TICKS_W-1:0];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.write_reg(i, val[i][TICKS_W-1:0]);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : status_drain
		int idle_left;
		int cyc;
		bit pop_now;
		bit calm;
		idle_left = 0;
		cyc = 0;
		calm = 1'b0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				idle_left = HOLD_CYCLES;
			end
			if (cyc % 128 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (idle_left > 0) begin
				pop_now = 1'b0;
				idle_left--;
			end else begin
				pop_now = 1'b1;
				if (!calm)
					idle_left = gap_len();
			end
			pop <= pop_now;
			@(posedge clk);
			cyc++;
			if (pop_now && !empty)
				sb.check_status(status, frame_word, bad_symbol);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout with %0d status items still expected", sb.pending());
		$display("** nec_ir_symbol_decoder_core: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int phase_start;
		sb = new();
		items_sent = 0;
		hold_request = 1'b0;
		burst_mode = 1'b0;
		tx_quiet = 1'b0;
		push <= 1'b0;
		mark_ticks <= '0;
		space_ticks <= '0;
		last_symbol <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MARGIN;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < N_PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				program_phase(phase);
			end
			phase_start = items_sent;
			if (phase == 0)
				directed_symbols();
			if (phase == 1) begin
				// receiver stops while repeat codes stream in, status queue backs up
				hold_request = 1'b1;
				burst_mode = 1'b1;
				repeat (24) send_frame(FR_REPEAT);
				burst_mode = 1'b0;
			end
			if (phase == 3 || phase == 5)
				send_frame(FR_LONG);
			while (items_sent - phase_start < PHASE_ITEMS)
				send_frame(pick_kind());
		end
		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** nec_ir_symbol_decoder_core: PASSED **");
		end else begin
			$display("** nec_ir_symbol_decoder_core: FAILED **");
		end
		$finish;
	end

endmodule
